// ===== hw/rtl/pcot_pkg.sv =====
// ----------------------------------------------------------------------------
// pcot_pkg: shared types and constants of the prescaled timer bank
// Command layout passed from the front end to the timer engine, opcode and
// register offset codes, mode word bit positions and back end states.
// ----------------------------------------------------------------------------
package pcot_pkg;

    localparam int BANK_DEPTH = 4;
    localparam int WORD_W     = 32;
    localparam int PRE_W      = 15;
    localparam int QUEUE_DEPTH = 2;

    // Reciprocal shift for the prescaler reduction: 15-bit dividend, divisor up to 2^15
    localparam int RED_SHIFT  = 30;
    localparam int MAGIC_W    = 31;
    localparam int PROD_W     = PRE_W + MAGIC_W;

    // Input opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register offsets
    localparam logic [1:0] OFF_COUNT   = 2'd0;
    localparam logic [1:0] OFF_MODE    = 2'd1;
    localparam logic [1:0] OFF_COMPARE = 2'd2;
    localparam logic [1:0] OFF_HOLD    = 2'd3;

    // Clock select codes
    localparam logic [1:0] CLK_BUS    = 2'd0;
    localparam logic [1:0] CLK_DIV16  = 2'd1;
    localparam logic [1:0] CLK_DIV256 = 2'd2;
    localparam logic [1:0] CLK_HBLANK = 2'd3;

    // Mode word bits
    localparam int BIT_CLEAR_CMP = 6;
    localparam int BIT_ENABLE    = 7;
    localparam int BIT_CMP_IE    = 8;
    localparam int BIT_OVF_IE    = 9;
    localparam int BIT_CMP_FLAG  = 10;
    localparam int BIT_OVF_FLAG  = 11;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_TICK,
        CMD_READ,
        CMD_WRITE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [1:0]        timer_index;
        logic [1:0]        reg_offset;
        logic [WORD_W-1:0] write_data;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_RED_MUL,
        BK_RED_SUB
    } bk_state_t;

endpackage

// ===== hw/rtl/pcot_front.sv =====
// ----------------------------------------------------------------------------
// pcot_front: input decode
// Classifies an incoming transaction into a tick, read, write or no-op command.
// Unused opcodes and accesses to absent timers become no-ops.
// ----------------------------------------------------------------------------
module pcot_front #(
    parameter int NUM_TIMERS = 4
) (
    input  logic [1:0]                 s_mode,
    input  logic [1:0]                 s_timer_index,
    input  logic [1:0]                 s_reg_offset,
    input  logic [pcot_pkg::WORD_W-1:0] s_write_data,
    output pcot_pkg::cmd_t             cmd
);

    logic present;

    assign present = int'(s_timer_index) < NUM_TIMERS;

    always_comb begin
        cmd.timer_index = s_timer_index;
        cmd.reg_offset  = s_reg_offset;
        cmd.write_data  = s_write_data;
        case (s_mode)
            pcot_pkg::OP_TICK:  cmd.kind = pcot_pkg::CMD_TICK;
            pcot_pkg::OP_READ:  cmd.kind = present ? pcot_pkg::CMD_READ : pcot_pkg::CMD_NOP;
            pcot_pkg::OP_WRITE: cmd.kind = present ? pcot_pkg::CMD_WRITE : pcot_pkg::CMD_NOP;
            default:            cmd.kind = pcot_pkg::CMD_NOP;
        endcase
    end

endmodule

// ===== hw/rtl/pcot_queue.sv =====
// ----------------------------------------------------------------------------
// pcot_queue: command queue
// Two-entry FIFO between the decode front end and the timer engine.
// ----------------------------------------------------------------------------
module pcot_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  pcot_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop,
    output pcot_pkg::cmd_t pop_cmd
);

    pcot_pkg::cmd_t entry_reg [pcot_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign push_ready = fill_reg != 2'(pcot_pkg::QUEUE_DEPTH);
    assign pop_valid  = fill_reg != 2'd0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/pcot_back.sv =====
// ----------------------------------------------------------------------------
// pcot_back: timer engine
// Holds the timer bank and registers each result, one command per cycle
// unless stalled. A mode write reduces the prescale counter modulo the new
// ratio with a two-step reciprocal multiply, holding the queue meanwhile.
// ----------------------------------------------------------------------------
module pcot_back #(
    parameter int NUM_TIMERS   = 4,
    parameter int RATIO_BUS    = 2,
    parameter int RATIO_DIV16  = 32,
    parameter int RATIO_DIV256 = 512,
    parameter int RATIO_HBLANK = 18743
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    input  pcot_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pcot_pkg::WORD_W-1:0] m_read_data,
    output logic [3:0]                  m_irq_pulse
);

    localparam int PW = pcot_pkg::PRE_W;
    localparam int WW = pcot_pkg::WORD_W;
    localparam int BD = pcot_pkg::BANK_DEPTH;

    localparam logic [PW-1:0] RATIO_0 = PW'(RATIO_BUS % 32768);
    localparam logic [PW-1:0] RATIO_1 = PW'(RATIO_DIV16 % 32768);
    localparam logic [PW-1:0] RATIO_2 = PW'(RATIO_DIV256 % 32768);
    localparam logic [PW-1:0] RATIO_3 = PW'(RATIO_HBLANK % 32768);

    localparam longint DIV_0 = longint'(RATIO_0) + 1;
    localparam longint DIV_1 = longint'(RATIO_1) + 1;
    localparam longint DIV_2 = longint'(RATIO_2) + 1;
    localparam longint DIV_3 = longint'(RATIO_3) + 1;

    localparam longint RED_ONE = longint'(1) << pcot_pkg::RED_SHIFT;
    localparam logic [pcot_pkg::MAGIC_W-1:0] MAGIC_0 =
        pcot_pkg::MAGIC_W'((RED_ONE + DIV_0 - 1) / DIV_0);
    localparam logic [pcot_pkg::MAGIC_W-1:0] MAGIC_1 =
        pcot_pkg::MAGIC_W'((RED_ONE + DIV_1 - 1) / DIV_1);
    localparam logic [pcot_pkg::MAGIC_W-1:0] MAGIC_2 =
        pcot_pkg::MAGIC_W'((RED_ONE + DIV_2 - 1) / DIV_2);
    localparam logic [pcot_pkg::MAGIC_W-1:0] MAGIC_3 =
        pcot_pkg::MAGIC_W'((RED_ONE + DIV_3 - 1) / DIV_3);

    // Timer bank
    logic [WW-1:0] count_reg   [BD];
    logic [WW-1:0] count_next  [BD];
    logic [WW-1:0] mode_reg    [BD];
    logic [WW-1:0] mode_next   [BD];
    logic [WW-1:0] compare_reg [BD];
    logic [WW-1:0] compare_next[BD];
    logic [WW-1:0] hold_reg    [BD];
    logic [WW-1:0] hold_next   [BD];
    logic [PW-1:0] pre_cnt_reg [BD];
    logic [PW-1:0] pre_cnt_next[BD];
    logic [PW-1:0] ratio_reg   [BD];
    logic [PW-1:0] ratio_next  [BD];

    // Reduction pipeline
    logic [1:0]                     red_idx_reg, red_idx_next;
    logic [1:0]                     red_sel_reg, red_sel_next;
    logic [PW-1:0]                  red_x_reg, red_x_next;
    logic [pcot_pkg::PROD_W-1:0]    red_prod_reg, red_prod_next;
    logic [pcot_pkg::MAGIC_W-1:0]   magic_sel;
    logic [PW:0]                    div_sel;
    logic [PW-1:0]                  red_quot;
    logic [PW-1:0]                  red_rem;

    // Result register
    logic          m_valid_reg, m_valid_next;
    logic [WW-1:0] m_read_data_reg, m_read_data_next;
    logic [3:0]    m_irq_pulse_reg, m_irq_pulse_next;

    pcot_pkg::bk_state_t state_reg, state_next;
    logic can_run, red_mul_en, red_sub_en;
    logic exec;
    logic mode_write;

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_irq_pulse = m_irq_pulse_reg;

    assign exec       = can_run && cmd_valid && (!m_valid_reg || m_ready);
    assign cmd_pop    = exec;
    assign mode_write = (cmd.kind == pcot_pkg::CMD_WRITE) &&
                        (cmd.reg_offset == pcot_pkg::OFF_MODE);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pcot_pkg::BK_RUN:     if (exec && mode_write) state_next = pcot_pkg::BK_RED_MUL;
            pcot_pkg::BK_RED_MUL: state_next = pcot_pkg::BK_RED_SUB;
            pcot_pkg::BK_RED_SUB: state_next = pcot_pkg::BK_RUN;
            default:              state_next = pcot_pkg::BK_RUN;
        endcase
    end

    // State outputs
    always_comb begin
        can_run    = 1'b0;
        red_mul_en = 1'b0;
        red_sub_en = 1'b0;
        case (state_reg)
            pcot_pkg::BK_RUN:     can_run    = 1'b1;
            pcot_pkg::BK_RED_MUL: red_mul_en = 1'b1;
            pcot_pkg::BK_RED_SUB: red_sub_en = 1'b1;
            default:              can_run    = 1'b0;
        endcase
    end

    always_comb begin
        case (red_sel_reg)
            pcot_pkg::CLK_BUS:    begin magic_sel = MAGIC_0; div_sel = (PW+1)'(DIV_0); end
            pcot_pkg::CLK_DIV16:  begin magic_sel = MAGIC_1; div_sel = (PW+1)'(DIV_1); end
            pcot_pkg::CLK_DIV256: begin magic_sel = MAGIC_2; div_sel = (PW+1)'(DIV_2); end
            default:              begin magic_sel = MAGIC_3; div_sel = (PW+1)'(DIV_3); end
        endcase
    end

    assign red_quot = red_prod_reg[pcot_pkg::RED_SHIFT +: PW];
    assign red_rem  = red_x_reg - PW'(32'(red_quot) * 32'(div_sel));

    always_comb begin
        logic [PW-1:0] np;
        logic [WW-1:0] c;
        logic [WW-1:0] m;
        logic          hit;
        logic          ovf;
        logic          irq;

        np  = '0;
        c   = '0;
        m   = '0;
        hit = 1'b0;
        ovf = 1'b0;
        irq = 1'b0;

        count_next   = count_reg;
        mode_next    = mode_reg;
        compare_next = compare_reg;
        hold_next    = hold_reg;
        pre_cnt_next = pre_cnt_reg;
        ratio_next   = ratio_reg;
        red_idx_next = red_idx_reg;
        red_sel_next = red_sel_reg;
        red_x_next   = red_x_reg;
        red_prod_next = red_prod_reg;
        m_read_data_next = m_read_data_reg;
        m_irq_pulse_next = m_irq_pulse_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        if (exec) begin
            m_valid_next     = 1'b1;
            m_read_data_next = '0;
            m_irq_pulse_next = '0;
            case (cmd.kind)
                pcot_pkg::CMD_TICK: begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        m = mode_reg[i];
                        if (m[pcot_pkg::BIT_ENABLE]) begin
                            // Prescale counter is kept reduced below ratio + 1
                            np = (pre_cnt_reg[i] == ratio_reg[i]) ? '0 : pre_cnt_reg[i] + 1'b1;
                            c  = (np == ratio_reg[i]) ? count_reg[i] + 1'b1 : count_reg[i];
                            irq = 1'b0;
                            hit = c == compare_reg[i];
                            if (hit) begin
                                irq = m[pcot_pkg::BIT_CMP_IE] && !m[pcot_pkg::BIT_CMP_FLAG];
                                if (m[pcot_pkg::BIT_CLEAR_CMP]) begin
                                    c = '0;
                                end
                                m[pcot_pkg::BIT_CMP_FLAG] = 1'b1;
                            end
                            ovf = |c[WW-1:16];
                            if (ovf) begin
                                if (m[pcot_pkg::BIT_OVF_IE] && !m[pcot_pkg::BIT_OVF_FLAG]) begin
                                    irq = 1'b1;
                                end
                                c = '0;
                                m[pcot_pkg::BIT_OVF_FLAG] = 1'b1;
                            end
                            pre_cnt_next[i]     = np;
                            count_next[i]       = c;
                            mode_next[i]        = m;
                            m_irq_pulse_next[i] = irq;
                        end
                    end
                end
                pcot_pkg::CMD_READ: begin
                    case (cmd.reg_offset)
                        pcot_pkg::OFF_COUNT:   m_read_data_next = count_reg[cmd.timer_index];
                        pcot_pkg::OFF_MODE:    m_read_data_next = mode_reg[cmd.timer_index];
                        pcot_pkg::OFF_COMPARE: m_read_data_next = compare_reg[cmd.timer_index];
                        default:               m_read_data_next = hold_reg[cmd.timer_index];
                    endcase
                end
                pcot_pkg::CMD_WRITE: begin
                    case (cmd.reg_offset)
                        pcot_pkg::OFF_COUNT: count_next[cmd.timer_index] = cmd.write_data;
                        pcot_pkg::OFF_MODE: begin
                            mode_next[cmd.timer_index] = cmd.write_data;
                            case (cmd.write_data[1:0])
                                pcot_pkg::CLK_BUS:    ratio_next[cmd.timer_index] = RATIO_0;
                                pcot_pkg::CLK_DIV16:  ratio_next[cmd.timer_index] = RATIO_1;
                                pcot_pkg::CLK_DIV256: ratio_next[cmd.timer_index] = RATIO_2;
                                default:              ratio_next[cmd.timer_index] = RATIO_3;
                            endcase
                            // Capture the prescale counter for reduction under the new ratio
                            red_idx_next = cmd.timer_index;
                            red_sel_next = cmd.write_data[1:0];
                            red_x_next   = pre_cnt_reg[cmd.timer_index];
                        end
                        pcot_pkg::OFF_COMPARE: compare_next[cmd.timer_index] = cmd.write_data;
                        default:               hold_next[cmd.timer_index] = cmd.write_data;
                    endcase
                end
                default: begin
                    m_read_data_next = '0;
                end
            endcase
        end

        if (red_mul_en) begin
            red_prod_next = pcot_pkg::PROD_W'(red_x_reg) * pcot_pkg::PROD_W'(magic_sel);
        end
        if (red_sub_en) begin
            pre_cnt_next[red_idx_reg] = red_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pcot_pkg::BK_RUN;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < BD; i++) begin
                count_reg[i]   <= '0;
                mode_reg[i]    <= '0;
                compare_reg[i] <= '0;
                hold_reg[i]    <= '0;
                pre_cnt_reg[i] <= '0;
                ratio_reg[i]   <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            mode_reg    <= mode_next;
            compare_reg <= compare_next;
            hold_reg    <= hold_next;
            pre_cnt_reg <= pre_cnt_next;
            ratio_reg   <= ratio_next;
        end
    end

    always_ff @(posedge aclk) begin
        red_idx_reg     <= red_idx_next;
        red_sel_reg     <= red_sel_next;
        red_x_reg       <= red_x_next;
        red_prod_reg    <= red_prod_next;
        m_read_data_reg <= m_read_data_next;
        m_irq_pulse_reg <= m_irq_pulse_next;
    end

endmodule

// ===== hw/rtl/prescaled_compare_overflow_timers_top.sv =====
// ----------------------------------------------------------------------------
// prescaled_compare_overflow_timers_top: bank of prescaled interval timers
// Up to four timers with compare and overflow interrupts, driven by tick,
// register read and register write transactions.
// ----------------------------------------------------------------------------
// Every input transaction (tick, read or write) yields exactly one result
// transaction. The block takes one transaction per cycle while the command
// queue has room; a write to a mode word holds the timer engine in its
// BK_RED_MUL and BK_RED_SUB states, where the prescale counter is reduced
// modulo the new ratio by a reciprocal multiply and a multiply-subtract. A
// two-entry command queue and a registered result stage let input and output
// stall independently; queued commands are executed into the result stage.
module prescaled_compare_overflow_timers_top #(
    parameter int NUM_TIMERS   = 4,
    parameter int RATIO_BUS    = 2,
    parameter int RATIO_DIV16  = 32,
    parameter int RATIO_DIV256 = 512,
    parameter int RATIO_HBLANK = 18743
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [1:0]                  s_timer_index,
    input  logic [1:0]                  s_reg_offset,
    input  logic [pcot_pkg::WORD_W-1:0] s_write_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pcot_pkg::WORD_W-1:0] m_read_data,
    output logic [3:0]                  m_irq_pulse
);

    pcot_pkg::cmd_t front_cmd;
    pcot_pkg::cmd_t queue_cmd;
    logic           queue_valid;
    logic           queue_pop;

    pcot_front #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_front (
        .s_mode       (s_mode),
        .s_timer_index(s_timer_index),
        .s_reg_offset (s_reg_offset),
        .s_write_data (s_write_data),
        .cmd          (front_cmd)
    );

    pcot_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(s_valid),
        .push_ready(s_ready),
        .push_cmd  (front_cmd),
        .pop_valid (queue_valid),
        .pop       (queue_pop),
        .pop_cmd   (queue_cmd)
    );

    pcot_back #(
        .NUM_TIMERS  (NUM_TIMERS),
        .RATIO_BUS   (RATIO_BUS),
        .RATIO_DIV16 (RATIO_DIV16),
        .RATIO_DIV256(RATIO_DIV256),
        .RATIO_HBLANK(RATIO_HBLANK)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (queue_valid),
        .cmd        (queue_cmd),
        .cmd_pop    (queue_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_read_data(m_read_data),
        .m_irq_pulse(m_irq_pulse)
    );

endmodule

// ===== hw/rtl/pcot_checker.sv =====
// ----------------------------------------------------------------------------
// pcot_port_assertions: port-level checks for the timer bank
// Watches the top-level result port and flags transactions that break the
// handshake or carry impossible field combinations.
// ----------------------------------------------------------------------------
module pcot_port_assertions #(
    parameter int NUM_TIMERS = 4
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [pcot_pkg::WORD_W-1:0] m_read_data,
    input logic [3:0]                  m_irq_pulse
);

    logic [3:0] absent_mask;

    assign absent_mask = 4'(4'hf << NUM_TIMERS);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_irq_pulse))
        else $error("result changed or dropped while stalled");

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A result is either a read word or a tick pulse, never both
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_read_data == '0 || m_irq_pulse == 4'd0))
        else $error("read data and interrupt pulse both set");

    // Absent timers never raise an interrupt
    a_absent_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_irq_pulse & absent_mask) == 4'd0)
        else $error("interrupt from absent timer");

endmodule

bind prescaled_compare_overflow_timers_top pcot_port_assertions #(
    .NUM_TIMERS(NUM_TIMERS)
) u_pcot_checker (.*);

// ===== tb/pcot_checker.sv =====
// ----------------------------------------------------------------------------
// pcot_checker: result checker for the prescaled timer bank
// Watches both channels. Each accepted input transaction is applied to a
// shadow copy of the timer bank to work out its result. Each accepted result
// is compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pcot_checker #(
    parameter int NUM_TIMERS   = 4,
    parameter int RATIO_BUS    = 2,
    parameter int RATIO_DIV16  = 32,
    parameter int RATIO_DIV256 = 512,
    parameter int RATIO_HBLANK = 18743
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [1:0]                  s_timer_index,
    input  logic [1:0]                  s_reg_offset,
    input  logic [pcot_pkg::WORD_W-1:0] s_write_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [pcot_pkg::WORD_W-1:0] m_read_data,
    input  logic [3:0]                  m_irq_pulse,
    output int                          fail_count,
    output int                          owed_count
);

    localparam int WW = pcot_pkg::WORD_W;
    localparam int PW = pcot_pkg::PRE_W;
    localparam int BD = pcot_pkg::BANK_DEPTH;

    localparam logic [WW-1:0] OVF_LIMIT = 32'h0000_ffff;

    typedef struct packed {
        logic [WW-1:0] read_data;
        logic [3:0]    irq_pulse;
    } timer_result_t;

    logic [WW-1:0] shadow_count   [BD];
    logic [WW-1:0] shadow_mode    [BD];
    logic [WW-1:0] shadow_compare [BD];
    logic [WW-1:0] shadow_hold    [BD];
    logic [PW-1:0] shadow_prescale[BD];
    logic [PW-1:0] shadow_ratio   [BD];

    timer_result_t owed_results[$];

    // Apply one transaction to the shadow bank and return the result it yields.
    function automatic timer_result_t bank_step(input logic [1:0] op,
                                                input logic [1:0] idx,
                                                input logic [1:0] off,
                                                input logic [WW-1:0] data);
        timer_result_t res;
        logic [WW-1:0] mw;
        int unsigned   nxt;
        bit            present;
        res = '0;
        present = (int'(idx) < NUM_TIMERS);
        case (op)
            pcot_pkg::OP_TICK: begin
                for (int t = 0; t < NUM_TIMERS && t < BD; t++) begin
                    mw = shadow_mode[t];
                    if (mw[pcot_pkg::BIT_ENABLE]) begin
                        nxt = (int'(shadow_prescale[t]) + 1) % (int'(shadow_ratio[t]) + 1);
                        shadow_prescale[t] = nxt[PW-1:0];
                        if (shadow_prescale[t] == shadow_ratio[t])
                            shadow_count[t] = shadow_count[t] + 1;
                        if (shadow_count[t] == shadow_compare[t]) begin
                            if (mw[pcot_pkg::BIT_CMP_IE] && !mw[pcot_pkg::BIT_CMP_FLAG])
                                res.irq_pulse[t] = 1'b1;
                            if (mw[pcot_pkg::BIT_CLEAR_CMP])
                                shadow_count[t] = '0;
                            mw[pcot_pkg::BIT_CMP_FLAG] = 1'b1;
                        end
                        if (shadow_count[t] > OVF_LIMIT) begin
                            if (mw[pcot_pkg::BIT_OVF_IE] && !mw[pcot_pkg::BIT_OVF_FLAG])
                                res.irq_pulse[t] = 1'b1;
                            shadow_count[t] = '0;
                            mw[pcot_pkg::BIT_OVF_FLAG] = 1'b1;
                        end
                        shadow_mode[t] = mw;
                    end
                end
            end
            pcot_pkg::OP_READ: begin
                if (present) begin
                    case (off)
                        pcot_pkg::OFF_COUNT:   res.read_data = shadow_count[idx];
                        pcot_pkg::OFF_MODE:    res.read_data = shadow_mode[idx];
                        pcot_pkg::OFF_COMPARE: res.read_data = shadow_compare[idx];
                        default:               res.read_data = shadow_hold[idx];
                    endcase
                end
            end
            pcot_pkg::OP_WRITE: begin
                if (present) begin
                    case (off)
                        pcot_pkg::OFF_COUNT: shadow_count[idx] = data;
                        pcot_pkg::OFF_MODE: begin
                            shadow_mode[idx] = data;
                            case (data[1:0])
                                pcot_pkg::CLK_BUS:    shadow_ratio[idx] = PW'(RATIO_BUS);
                                pcot_pkg::CLK_DIV16:  shadow_ratio[idx] = PW'(RATIO_DIV16);
                                pcot_pkg::CLK_DIV256: shadow_ratio[idx] = PW'(RATIO_DIV256);
                                default:              shadow_ratio[idx] = PW'(RATIO_HBLANK);
                            endcase
                        end
                        pcot_pkg::OFF_COMPARE: shadow_compare[idx] = data;
                        default:               shadow_hold[idx] = data;
                    endcase
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        timer_result_t due;
        if (!aresetn) begin
            for (int t = 0; t < BD; t++) begin
                shadow_count[t]    = '0;
                shadow_mode[t]     = '0;
                shadow_compare[t]  = '0;
                shadow_hold[t]     = '0;
                shadow_prescale[t] = '0;
                shadow_ratio[t]    = '0;
            end
            owed_results.delete();
        end else begin
            // Retire first: a result never belongs to a transaction accepted on this edge.
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected result: read_data %h irq_pulse %h",
                                 $time, m_read_data, m_irq_pulse);
                end else begin
                    due = owed_results.pop_front();
                    if (m_read_data !== due.read_data || m_irq_pulse !== due.irq_pulse) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"[%0t] mismatch: read_data exp %h got %h,",
                                      " irq_pulse exp %h got %h"},
                                     $time, due.read_data, m_read_data,
                                     due.irq_pulse, m_irq_pulse);
                    end
                end
            end
            if (s_valid && s_ready)
                owed_results.push_back(bank_step(s_mode, s_timer_index, s_reg_offset,
                                                 s_write_data));
        end
        owed_count = owed_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the prescaled timer bank
// Drives a directed opening (a reset, every opcode, all clock selects, compare
// and overflow events, blocked flags) and then phases of shaped random
// transactions under varied sender idling and receiver stalls, including a
// long receiver hold-off and a full drain. Checking is done by pcot_checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_TIMERS   = 4;
    localparam int RATIO_BUS    = 2;
    localparam int RATIO_DIV16  = 32;
    localparam int RATIO_DIV256 = 512;
    localparam int RATIO_HBLANK = 18743;

    localparam int WW = pcot_pkg::WORD_W;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int PHASE_ITEMS = 470;
    localparam int LONG_HOLD   = 60;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 200000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [1:0]    s_mode = '0;
    logic [1:0]    s_timer_index = '0;
    logic [1:0]    s_reg_offset = '0;
    logic [WW-1:0] s_write_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [WW-1:0] m_read_data;
    logic [3:0]    m_irq_pulse;

    int fail_count;
    int owed_count;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycles = 0;
    bit hold_request = 1'b0;

    localparam logic [WW-1:0] RUN_BUS =
        (32'd1 << pcot_pkg::BIT_ENABLE) | 32'(pcot_pkg::CLK_BUS);

    prescaled_compare_overflow_timers_top #(
        .NUM_TIMERS  (NUM_TIMERS),
        .RATIO_BUS   (RATIO_BUS),
        .RATIO_DIV16 (RATIO_DIV16),
        .RATIO_DIV256(RATIO_DIV256),
        .RATIO_HBLANK(RATIO_HBLANK)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_timer_index(s_timer_index),
        .s_reg_offset (s_reg_offset),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_irq_pulse  (m_irq_pulse)
    );

    pcot_checker #(
        .NUM_TIMERS  (NUM_TIMERS),
        .RATIO_BUS   (RATIO_BUS),
        .RATIO_DIV16 (RATIO_DIV16),
        .RATIO_DIV256(RATIO_DIV256),
        .RATIO_HBLANK(RATIO_HBLANK)
    ) bank_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_timer_index(s_timer_index),
        .s_reg_offset (s_reg_offset),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_irq_pulse  (m_irq_pulse),
        .fail_count   (fail_count),
        .owed_count   (owed_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** prescaled_compare_overflow_timers_top: FAILED **");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer(input logic [1:0] op, input logic [1:0] idx,
                         input logic [1:0] off, input logic [WW-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= op;
        s_timer_index <= idx;
        s_reg_offset  <= off;
        s_write_data  <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_bank();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (owed_count != 0) @(negedge aclk);
    endtask

    // Mostly small counts and compares on the fast clock select so that
    // compare and overflow events happen often; the rest is wide noise.
    task automatic offer_random_item();
        int            pick;
        logic [1:0]    idx;
        logic [1:0]    off;
        logic [WW-1:0] word;
        pick = $urandom_range(99);
        idx  = 2'($urandom_range(3));
        off  = 2'($urandom_range(3));
        word = $urandom;
        if (pick < 45) begin
            offer(pcot_pkg::OP_TICK, idx, off, word);
        end else if (pick < 65) begin
            offer(pcot_pkg::OP_READ, idx, off, word);
        end else if (pick < 95) begin
            if (off == pcot_pkg::OFF_MODE) begin
                word[1:0] = ($urandom_range(99) < 80) ? pcot_pkg::CLK_BUS
                                                       : 2'($urandom_range(3));
                word[pcot_pkg::BIT_ENABLE]   = ($urandom_range(99) < 85);
                word[pcot_pkg::BIT_CMP_FLAG] = ($urandom_range(99) < 20);
                word[pcot_pkg::BIT_OVF_FLAG] = ($urandom_range(99) < 20);
            end else if (off != pcot_pkg::OFF_HOLD) begin
                case ($urandom_range(3))
                    0: word = 32'($urandom_range(12));
                    1: word = 32'h0000_ffff - 32'($urandom_range(6));
                    2: word = 32'h0001_0000 + 32'($urandom_range(3));
                    default: ;
                endcase
            end
            offer(pcot_pkg::OP_WRITE, idx, off, word);
        end else begin
            offer(OP_UNUSED, idx, off, word);
        end
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed opening
        offer(pcot_pkg::OP_READ, 2'd0, pcot_pkg::OFF_COUNT, '0);
        offer(pcot_pkg::OP_TICK, 2'd3, pcot_pkg::OFF_HOLD, 32'hffff_ffff);
        offer(OP_UNUSED, 2'd3, pcot_pkg::OFF_HOLD, 32'hffff_ffff);
        // timer 0: compare match with interrupt and clear
        offer(pcot_pkg::OP_WRITE, 2'd0, pcot_pkg::OFF_COMPARE, 32'd2);
        offer(pcot_pkg::OP_WRITE, 2'd0, pcot_pkg::OFF_MODE,
              RUN_BUS | (32'd1 << pcot_pkg::BIT_CMP_IE) | (32'd1 << pcot_pkg::BIT_CLEAR_CMP));
        // timer 1: overflow from the top of the 16-bit range
        offer(pcot_pkg::OP_WRITE, 2'd1, pcot_pkg::OFF_COUNT, 32'h0000_ffff);
        offer(pcot_pkg::OP_WRITE, 2'd1, pcot_pkg::OFF_MODE,
              RUN_BUS | (32'd1 << pcot_pkg::BIT_OVF_IE));
        // timer 2: overflow on the first tick, slowest prescale
        offer(pcot_pkg::OP_WRITE, 2'd2, pcot_pkg::OFF_COUNT, 32'hffff_ffff);
        offer(pcot_pkg::OP_WRITE, 2'd2, pcot_pkg::OFF_MODE,
              (32'd1 << pcot_pkg::BIT_ENABLE) | (32'd1 << pcot_pkg::BIT_OVF_IE) |
              32'(pcot_pkg::CLK_HBLANK));
        // timer 3: every bit set, so both flags block the interrupts
        offer(pcot_pkg::OP_WRITE, 2'd3, pcot_pkg::OFF_MODE, 32'hffff_ffff);
        offer(pcot_pkg::OP_WRITE, 2'd3, pcot_pkg::OFF_HOLD, 32'hffff_ffff);
        offer(pcot_pkg::OP_WRITE, 2'd3, pcot_pkg::OFF_COMPARE, '0);
        repeat (6) offer(pcot_pkg::OP_TICK, 2'd0, pcot_pkg::OFF_COUNT, '0);
        offer(pcot_pkg::OP_READ, 2'd3, pcot_pkg::OFF_MODE, '0);
        offer(pcot_pkg::OP_READ, 2'd3, pcot_pkg::OFF_HOLD, '0);
        offer(pcot_pkg::OP_READ, 2'd1, pcot_pkg::OFF_MODE, '0);
        offer(pcot_pkg::OP_READ, 2'd0, pcot_pkg::OFF_COUNT, '0);
        offer(pcot_pkg::OP_WRITE, 2'd0, pcot_pkg::OFF_MODE,
              RUN_BUS | 32'(pcot_pkg::CLK_DIV16));
        offer(pcot_pkg::OP_WRITE, 2'd1, pcot_pkg::OFF_MODE,
              RUN_BUS | 32'(pcot_pkg::CLK_DIV256));
        offer(pcot_pkg::OP_WRITE, 2'd2, pcot_pkg::OFF_COUNT, '0);
        drain_bank();

        // No idling, with one long receiver hold-off a third of the way through
        send_idle_pct = 0;
        sink_stall_pct = 0;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 3)
                hold_request = 1'b1;
            offer_random_item();
        end
        drain_bank();

        send_idle_pct = 83;
        for (int n = 0; n < PHASE_ITEMS; n++) offer_random_item();
        drain_bank();

        send_idle_pct = 0;
        sink_stall_pct = 83;
        for (int n = 0; n < PHASE_ITEMS; n++) offer_random_item();
        drain_bank();

        send_idle_pct = 29;
        sink_stall_pct = 29;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2)
                hold_request = 1'b1;
            offer_random_item();
        end
        drain_bank();

        repeat (SETTLE) @(negedge aclk);
        if (fail_count == 0 && owed_count == 0)
            $display("** prescaled_compare_overflow_timers_top: PASSED **");
        else
            $display("** prescaled_compare_overflow_timers_top: FAILED **");
        $finish;
    end

endmodule
